>>> hdl/swls_pkg.sv
package swls_pkg;

   // Width of the color field of a write request.
   localparam int COLOR_W = 24;

   // Width of every timing register.
   localparam int TICKS_W = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LATCH_LOW  = 3'd4;

   // Reset values of the timing registers.
   localparam logic [TICKS_W-1:0] RST_ZERO_HIGH = 16'd7;
   localparam logic [TICKS_W-1:0] RST_ZERO_LOW  = 16'd27;
   localparam logic [TICKS_W-1:0] RST_ONE_HIGH  = 16'd27;
   localparam logic [TICKS_W-1:0] RST_ONE_LOW   = 16'd7;
   localparam logic [TICKS_W-1:0] RST_LATCH_LOW = 16'd1000;

   // Request codes as they arrive on the input channel.
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_LATCH = 2'd2;

   // Depth of the queue between the front and the back end.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_LATCH = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [COLOR_W-1:0] color;
   } req_payload_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic rejected;
   } rsp_payload_type;

   typedef struct packed {
      logic [TICKS_W-1:0] zero_high;
      logic [TICKS_W-1:0] zero_low;
      logic [TICKS_W-1:0] one_high;
      logic [TICKS_W-1:0] one_low;
      logic [TICKS_W-1:0] latch_low;
   } timing_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // A programmed duration of zero behaves as one tick.
   function automatic logic [TICKS_W-1:0] at_least_one(input logic [TICKS_W-1:0] value);
      logic [TICKS_W-1:0] result;
      result = (value == '0) ? TICKS_W'(1) : value;
      return result;
   endfunction

endpackage

>>> hdl/swls_front.sv
module swls_front #(
   parameter int BITS_PER_LED = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  swls_pkg::req_payload_type      req_data,
   input  swls_pkg::queue_status_type     queue_status,
   output logic                           push,
   output swls_pkg::op_type               push_op,
   output logic [BITS_PER_LED-1:0]        push_word
);
   import swls_pkg::*;

   logic                    stage_valid_ff;
   logic                    stage_valid_in;
   op_type                  stage_op_ff;
   op_type                  stage_op_in;
   logic [BITS_PER_LED-1:0] stage_word_ff;
   logic [BITS_PER_LED-1:0] stage_word_in;
   logic [BITS_PER_LED-1:0] color_word;
   op_type                  decoded_op;
   logic                    accept;

   // Fit the color field to the word that is shifted out.
   generate
      if (BITS_PER_LED > COLOR_W) begin : g_wide
         assign color_word = {{(BITS_PER_LED - COLOR_W){1'b0}}, req_data.color};
      end else if (BITS_PER_LED == COLOR_W) begin : g_exact
         assign color_word = req_data.color;
      end else begin : g_narrow
         assign color_word = req_data.color[BITS_PER_LED-1:0];
      end
   endgenerate

   always_comb begin
      unique case (req_data.req_type)
         REQ_TICK:  decoded_op = OP_TICK;
         REQ_WRITE: decoded_op = OP_WRITE;
         REQ_LATCH: decoded_op = OP_LATCH;
         default:   decoded_op = OP_NONE;
      endcase
   end

   assign push      = stage_valid_ff && !queue_status.full;
   assign req_ready = !stage_valid_ff || !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign push_op   = stage_op_ff;
   assign push_word = stage_word_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_op_in    = stage_op_ff;
      stage_word_in  = stage_word_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_op_in    = decoded_op;
         stage_word_in  = color_word;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_op_ff   <= stage_op_in;
      stage_word_ff <= stage_word_in;
   end

endmodule

>>> hdl/swls_queue.sv
module swls_queue #(
   parameter int BITS_PER_LED = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  swls_pkg::op_type            push_op,
   input  logic [BITS_PER_LED-1:0]     push_word,
   input  logic                        pop,
   output swls_pkg::op_type            pop_op,
   output logic [BITS_PER_LED-1:0]     pop_word,
   output swls_pkg::queue_status_type  queue_status
);
   import swls_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

   op_type                  op_ff   [QUEUE_DEPTH];
   logic [BITS_PER_LED-1:0] word_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff;
   logic [PTR_W-1:0]        wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [PTR_W-1:0]        rd_ptr_in;
   logic [COUNT_W-1:0]      count_ff;
   logic [COUNT_W-1:0]      count_in;

   assign queue_status.full  = (count_ff == FULL_COUNT);
   assign queue_status.empty = (count_ff == '0);
   assign pop_op   = op_ff[rd_ptr_ff];
   assign pop_word = word_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         op_ff[wr_ptr_ff]   <= push_op;
         word_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> hdl/swls_back.sv
module swls_back #(
   parameter int BITS_PER_LED = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  swls_pkg::timing_type        timing,
   input  swls_pkg::queue_status_type  queue_status,
   input  swls_pkg::op_type            pop_op,
   input  logic [BITS_PER_LED-1:0]     pop_word,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output swls_pkg::rsp_payload_type   rsp_data
);
   import swls_pkg::*;

   localparam int CNT_W = $clog2(BITS_PER_LED);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_LED - 1);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_HIGH  = 4'b0010,
      PH_LOW   = 4'b0100,
      PH_LATCH = 4'b1000
   } phase_type;

   phase_type               phase_ff;
   phase_type               phase_in;
   logic [TICKS_W-1:0]      left_ff;
   logic [TICKS_W-1:0]      left_in;
   logic [BITS_PER_LED-1:0] shift_ff;
   logic [BITS_PER_LED-1:0] shift_in;
   logic [CNT_W-1:0]        remaining_ff;
   logic [CNT_W-1:0]        remaining_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_payload_type         rsp_data_ff;
   rsp_payload_type         rsp_data_in;
   logic                    busy;
   logic                    rejected;
   logic [BITS_PER_LED-1:0] shifted;

   assign busy    = (phase_ff != PH_IDLE);
   assign shifted = {shift_ff[BITS_PER_LED-2:0], 1'b0};

   // One queued item is executed per cycle whenever the result register can take it.
   assign pop = !queue_status.empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      phase_in     = phase_ff;
      left_in      = left_ff;
      shift_in     = shift_ff;
      remaining_in = remaining_ff;
      rejected     = 1'b0;
      unique case (pop_op)
         OP_TICK: begin
            if (busy) begin
               if (left_ff > TICKS_W'(1)) begin
                  left_in = left_ff - TICKS_W'(1);
               end else begin
                  left_in = '0;
                  // The phase has run out, so the next one starts in the same tick.
                  if (phase_ff == PH_HIGH) begin
                     phase_in = PH_LOW;
                     left_in  = at_least_one(shift_ff[BITS_PER_LED-1] ?
                                             timing.one_low : timing.zero_low);
                  end else if (phase_ff == PH_LOW && remaining_ff != '0) begin
                     phase_in     = PH_HIGH;
                     shift_in     = shifted;
                     remaining_in = remaining_ff - CNT_W'(1);
                     left_in      = at_least_one(shifted[BITS_PER_LED-1] ?
                                                 timing.one_high : timing.zero_high);
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
         end
         OP_WRITE: begin
            if (busy) begin
               rejected = 1'b1;
            end else begin
               phase_in     = PH_HIGH;
               shift_in     = pop_word;
               remaining_in = LAST_BIT;
               left_in      = at_least_one(pop_word[BITS_PER_LED-1] ?
                                           timing.one_high : timing.zero_high);
            end
         end
         OP_LATCH: begin
            if (busy) begin
               rejected = 1'b1;
            end else begin
               phase_in = PH_LATCH;
               left_in  = at_least_one(timing.latch_low);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in.line_level = (phase_in == PH_HIGH);
      rsp_data_in.busy_res   = (phase_in != PH_IDLE);
      rsp_data_in.rejected   = rejected;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         left_ff      <= '0;
         shift_ff     <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff     <= phase_in;
            left_ff      <= left_in;
            shift_ff     <= shift_in;
            remaining_ff <= remaining_in;
         end
      end
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/single_wire_led_serializer.sv
// Pulse-width encoder for a single-wire LED data line.
// Requests arrive on the req_ channel (valid/ready). A tick advances the
// waveform by one tick of line time, a write loads a color word that is sent
// most significant bit first, and a latch holds the line low for the latch
// time. Every request yields exactly one transfer on the rsp_ channel with the
// line level after that request, a busy flag, and a rejected flag for a write
// or latch that arrived while a color or latch period was still in progress.
// The csr_ port writes the five timing registers; write it only while idle.
// A request passes the front decode register and the two-entry queue, whose
// head is executed into the response register. Throughput is one request per
// cycle while the receiver does not stall; the single step of the sequencer
// per request is what sets that figure. When the receiver stalls, the queue
// and front register absorb up to three more requests, then req_ready drops;
// after a long stall the front register waits for the full flag to clear,
// even while the full queue drains. Reset returns the line to idle low, clears
// the queue and the pending response, and restores the default timing values.
module single_wire_led_serializer #(
   parameter int BITS_PER_LED = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  swls_pkg::req_payload_type              req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output swls_pkg::rsp_payload_type              rsp_data,
   input  logic                                   csr_we,
   input  logic [swls_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [swls_pkg::TICKS_W-1:0]           csr_wdata
);
   import swls_pkg::*;

   timing_type              timing_ff;
   timing_type              timing_in;
   queue_status_type        queue_status;
   logic                    push;
   op_type                  push_op;
   logic [BITS_PER_LED-1:0] push_word;
   logic                    pop;
   op_type                  pop_op;
   logic [BITS_PER_LED-1:0] pop_word;

   always_comb begin
      timing_in = timing_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ZERO_HIGH: timing_in.zero_high = csr_wdata;
            CSR_ZERO_LOW:  timing_in.zero_low  = csr_wdata;
            CSR_ONE_HIGH:  timing_in.one_high  = csr_wdata;
            CSR_ONE_LOW:   timing_in.one_low   = csr_wdata;
            CSR_LATCH_LOW: timing_in.latch_low = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.zero_high <= RST_ZERO_HIGH;
         timing_ff.zero_low  <= RST_ZERO_LOW;
         timing_ff.one_high  <= RST_ONE_HIGH;
         timing_ff.one_low   <= RST_ONE_LOW;
         timing_ff.latch_low <= RST_LATCH_LOW;
      end else begin
         timing_ff <= timing_in;
      end
   end

   swls_front #(
      .BITS_PER_LED (BITS_PER_LED)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .queue_status (queue_status),
      .push         (push),
      .push_op      (push_op),
      .push_word    (push_word)
   );

   swls_queue #(
      .BITS_PER_LED (BITS_PER_LED)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_op      (push_op),
      .push_word    (push_word),
      .pop          (pop),
      .pop_op       (pop_op),
      .pop_word     (pop_word),
      .queue_status (queue_status)
   );

   swls_back #(
      .BITS_PER_LED (BITS_PER_LED)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .timing       (timing_ff),
      .queue_status (queue_status),
      .pop_op       (pop_op),
      .pop_word     (pop_word),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

`ifndef SYNTH
   // A dropped request leaves the running transfer untouched, so the line stays busy.
   a_reject_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |-> rsp_data.busy_res)
      else $error("rejected response without busy line");

   // A high line is always part of a bit in progress.
   a_high_means_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_level |-> rsp_data.busy_res)
      else $error("line high while idle");

   // The front end never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_status.full)
      else $error("queue overflow");

   // Nothing can be executed from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("queue underflow");
`endif

endmodule

>>> tb/tb_single_wire_led_serializer.sv
module tb_single_wire_led_serializer;
   timeunit 1ns;
   timeprecision 1ps;

   import swls_pkg::*;

   localparam int LED_BITS = 24;
   localparam int CLOCK_PERIOD = 8;
   localparam longint TIMEOUT_CYCLES = 2_000_000;
   // Random requests per idling pattern, ignored requests not counted.
   localparam int RANDOM_REQUESTS = 120;

   typedef enum logic [1:0] {
      LINE_IDLE  = 2'd0,
      LINE_HIGH  = 2'd1,
      LINE_LOW   = 2'd2,
      LINE_LATCH = 2'd3
   } line_phase_e;

   class led_line_scoreboard;
      timing_type timing;
      logic [LED_BITS-1:0] shift_word;
      int unsigned bits_left;
      int unsigned ticks_left;
      line_phase_e phase;
      rsp_payload_type expected_levels[$];
      int errors;
      int requests;
      int writes;
      int latches;
      int dropped;
      int settings;

      function new();
         timing = '{RST_ZERO_HIGH, RST_ZERO_LOW, RST_ONE_HIGH, RST_ONE_LOW, RST_LATCH_LOW};
         shift_word = '0;
         phase = LINE_IDLE;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [TICKS_W-1:0] value);
         case (index)
            CSR_ZERO_HIGH: timing.zero_high = value;
            CSR_ZERO_LOW:  timing.zero_low = value;
            CSR_ONE_HIGH:  timing.one_high = value;
            CSR_ONE_LOW:   timing.one_low = value;
            CSR_LATCH_LOW: timing.latch_low = value;
            default: ;
         endcase
      endfunction

      function bit busy();
         return phase != LINE_IDLE;
      endfunction

      // A programmed duration of zero still lasts one tick.
      function int unsigned duration(logic [TICKS_W-1:0] ticks);
         return (ticks == '0) ? 1 : int'(ticks);
      endfunction

      function void begin_high();
         phase = LINE_HIGH;
         ticks_left = duration(shift_word[LED_BITS-1] ? timing.one_high : timing.zero_high);
      endfunction

      function void begin_low();
         phase = LINE_LOW;
         ticks_left = duration(shift_word[LED_BITS-1] ? timing.one_low : timing.zero_low);
      endfunction

      function void advance_line();
         if (phase == LINE_IDLE) return;
         if (ticks_left > 1) begin
            ticks_left--;
            return;
         end
         ticks_left = 0;
         if (phase == LINE_HIGH) begin
            begin_low();
         end else if (phase == LINE_LOW && bits_left > 0) begin
            shift_word = shift_word << 1;
            bits_left--;
            begin_high();
         end else begin
            phase = LINE_IDLE;
         end
      endfunction

      function void note_request(req_payload_type item);
         rsp_payload_type want;
         bit was_busy;
         was_busy = busy();
         want.rejected = 1'b0;
         case (op_type'(item.req_type))
            OP_TICK: begin
               advance_line();
               requests++;
            end
            OP_WRITE, OP_LATCH: begin
               requests++;
               if (was_busy) begin
                  want.rejected = 1'b1;
                  dropped++;
               end else if (op_type'(item.req_type) == OP_WRITE) begin
                  shift_word = LED_BITS'(item.color);
                  bits_left = LED_BITS - 1;
                  begin_high();
                  writes++;
               end else begin
                  phase = LINE_LATCH;
                  ticks_left = duration(timing.latch_low);
                  latches++;
               end
            end
            default: ;
         endcase
         want.line_level = (phase == LINE_HIGH);
         want.busy_res = (phase != LINE_IDLE);
         expected_levels.push_back(want);
      endfunction

      function void compare_bit(string field, logic want, logic got);
         if (got !== want) begin
            $display("%0t: %s expected %b, got %b", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_levels.size() == 0) begin
            $display("%0t: response %b arrived with nothing expected", $time, got);
            errors++;
            return;
         end
         want = expected_levels.pop_front();
         compare_bit("line_level", want.line_level, got.line_level);
         compare_bit("busy_res", want.busy_res, got.busy_res);
         compare_bit("rejected", want.rejected, got.rejected);
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TICKS_W-1:0] csr_wdata = '0;

   int req_gap_pct = 16;
   int rsp_stall_pct = 63;
   led_line_scoreboard line_check = new();

   single_wire_led_serializer #(
      .BITS_PER_LED(LED_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Timed out with %0d responses outstanding.", line_check.expected_levels.size());
      $display("== FAIL ==");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) line_check.check_response(rsp_data);
   end

   // All driving tasks start and end on a falling edge.
   task automatic send_item(input op_type op, input logic [COLOR_W-1:0] color);
      req_payload_type item;
      item.req_type = op;
      item.color = color;
      while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      line_check.note_request(item);
      @(negedge clock);
   endtask

   task automatic send_noise();
      case ($urandom_range(2))
         0: send_item(OP_WRITE, COLOR_W'($urandom()));
         1: send_item(OP_LATCH, COLOR_W'($urandom()));
         default: send_item(OP_NONE, COLOR_W'($urandom()));
      endcase
   endtask

   // Ticks the line until the current color or latch period is over, with
   // stray requests mixed in at the given percentage.
   task automatic run_out(input int noise_pct);
      while (line_check.busy()) begin
         if ($urandom_range(99) < noise_pct) send_noise();
         else send_item(OP_TICK, COLOR_W'($urandom()));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (line_check.expected_levels.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [TICKS_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      line_check.write_reg(index, value);
      @(negedge clock);
   endtask

   task automatic program_timing(input timing_type t);
      write_csr(CSR_ZERO_HIGH, t.zero_high);
      write_csr(CSR_ZERO_LOW, t.zero_low);
      write_csr(CSR_ONE_HIGH, t.one_high);
      write_csr(CSR_ONE_LOW, t.one_low);
      write_csr(CSR_LATCH_LOW, t.latch_low);
      csr_we <= 1'b0;
      line_check.settings++;
   endtask

   function automatic logic [TICKS_W-1:0] pick_ticks(input int longest);
      return ($urandom_range(7) == 0) ? '0 : TICKS_W'($urandom_range(1, longest));
   endfunction

   function automatic timing_type random_timing();
      timing_type t;
      int longest;
      longest = ($urandom_range(9) == 0) ? 12 : 3;
      t.zero_high = pick_ticks(longest);
      t.zero_low = pick_ticks(longest);
      t.one_high = pick_ticks(longest);
      t.one_low = pick_ticks(longest);
      t.latch_low = pick_ticks(4 * longest);
      return t;
   endfunction

   task automatic random_sequence();
      int choice;
      choice = $urandom_range(99);
      if (choice < 70) begin
         case ($urandom_range(9))
            0: send_item(OP_WRITE, '1);
            1: send_item(OP_WRITE, '0);
            default: send_item(OP_WRITE, COLOR_W'($urandom()));
         endcase
         run_out(8);
      end else if (choice < 85) begin
         send_item(OP_LATCH, COLOR_W'($urandom()));
         run_out(8);
      end else begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(1)) send_item(OP_TICK, COLOR_W'($urandom()));
            else send_item(OP_NONE, COLOR_W'($urandom()));
         end
      end
   endtask

   initial begin
      int target;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed checks: idle requests at the reset timing, then a color that
      // keeps the reset zero-high and one-low times, with requests dropped
      // while it is sent.
      send_item(OP_TICK, '0);
      send_item(OP_NONE, '1);
      settle();
      write_csr(CSR_ZERO_LOW, 16'd1);
      write_csr(CSR_ONE_HIGH, 16'd1);
      csr_we <= 1'b0;
      send_item(OP_WRITE, 24'hA5C30F);
      send_item(OP_LATCH, '1);
      send_item(OP_WRITE, 24'h5A3CF0);
      send_item(OP_NONE, '0);
      run_out(0);

      // Zero durations behave as one tick, and indexes past the last
      // register leave the timing untouched.
      settle();
      program_timing('{default: '0});
      @(negedge clock);
      for (int idx = int'(CSR_LATCH_LOW) + 1; idx < (1 << CSR_INDEX_W); idx++) begin
         write_csr(CSR_INDEX_W'(idx), TICKS_W'($urandom()));
      end
      csr_we <= 1'b0;
      send_item(OP_WRITE, 24'h800001);
      run_out(0);
      send_item(OP_LATCH, '0);
      run_out(0);

      for (int pattern = 0; pattern < 3; pattern++) begin
         case (pattern)
            0: begin
               req_gap_pct = 16;
               rsp_stall_pct = 63;
            end
            1: begin
               req_gap_pct = 63;
               rsp_stall_pct = 16;
            end
            default: begin
               req_gap_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         target = line_check.requests + RANDOM_REQUESTS;
         while (line_check.requests < target) begin
            settle();
            program_timing(random_timing());
            repeat ($urandom_range(1, 2)) random_sequence();
         end
      end

      settle();
      repeat (10) @(posedge clock);
      $display("Checked %0d requests: %0d colors, %0d latches, %0d dropped while busy.",
               line_check.requests, line_check.writes, line_check.latches,
               line_check.dropped);
      $display("Covered %0d timing settings of zero to 48 ticks under three idling patterns; errors: %0d.",
               line_check.settings, line_check.errors);
      if (line_check.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
